FILE: hw/rtl/sfr_pkg.sv
// Shared types and constants for the serial frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package sfr_pkg;

   // Item kinds on the request channel.
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_TICK = 1'b1;

   // Frame layout and counter limits.
   localparam logic [3:0] FRAME_LEN   = 4'd9;
   localparam logic [3:0] SUM_LEN     = 4'd7;
   localparam logic [3:0] COUNT_MAX   = 4'd15;
   localparam logic [7:0] HEADER_BYTE = 8'd2;

   // Configuration registers.
   localparam int          CSR_ADDR_WIDTH   = 3;
   localparam logic        REG_IDLE_TIMEOUT = 1'b0;
   localparam logic [7:0]  TIMEOUT_RESET    = 8'd20;

   typedef enum logic [1:0] {
      STATUS_OK           = 2'd0,
      STATUS_SHORT        = 2'd1,
      STATUS_BAD_HEADER   = 2'd2,
      STATUS_BAD_CHECKSUM = 2'd3
   } status_type;

   // Request word: one received byte or one timer tick.
   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } req_type;

   // Result word.
   typedef struct packed {
      status_type  status;
      logic [15:0] error_code;
      logic [15:0] rpm;
   } rsp_type;

   // Closed frame as handed from the front to the back.
   typedef struct packed {
      logic        short_frame;
      logic [7:0]  header;
      logic [15:0] error_code;
      logic [15:0] rpm;
      logic [15:0] check;
      logic [15:0] sum;
   } frame_rec_type;

endpackage
`default_nettype wire

FILE: hw/rtl/sfr_front.sv
// Front end: frame buffer, running sum, idle timer and frame closing.
`timescale 1ns / 1ps
`default_nettype none
module sfr_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   item_accept,
   input  wire sfr_pkg::req_type       item,
   input  wire logic [7:0]             idle_timeout,
   output logic                        rec_push,
   output sfr_pkg::frame_rec_type      rec
);

   logic [7:0]  frame_ff [9];
   logic [3:0]  byte_count_ff, byte_count_in;
   logic [7:0]  idle_ff, idle_in;
   logic [15:0] sum_ff, sum_in;
   logic        is_byte, is_tick, close_frame;
   logic [7:0]  idle_dec;

   assign is_byte = item_accept && (item.kind == sfr_pkg::KIND_BYTE);
   assign is_tick = item_accept && (item.kind == sfr_pkg::KIND_TICK);

   // Timer counts down to zero and stays there.
   assign idle_dec    = (idle_ff != 8'd0) ? idle_ff - 8'd1 : 8'd0;
   assign close_frame = is_tick && (idle_dec == 8'd0) && (byte_count_ff != 4'd0);

   // Next values of the counters and the running sum of the first seven bytes.
   always_comb begin
      byte_count_in = byte_count_ff;
      idle_in       = idle_ff;
      sum_in        = sum_ff;
      if (is_byte) begin
         idle_in = idle_timeout;
         if (byte_count_ff < sfr_pkg::COUNT_MAX) begin
            byte_count_in = byte_count_ff + 4'd1;
         end
         if (byte_count_ff == 4'd0) begin
            sum_in = {8'h00, item.rx_byte};
         end else if (byte_count_ff < sfr_pkg::SUM_LEN) begin
            sum_in = sum_ff + {8'h00, item.rx_byte};
         end
      end else if (is_tick) begin
         idle_in = idle_dec;
         if (close_frame) begin
            byte_count_in = 4'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= 4'd0;
         idle_ff       <= 8'd0;
      end else begin
         byte_count_ff <= byte_count_in;
         idle_ff       <= idle_in;
      end
   end

   // Payload storage: no reset needed.
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      if (is_byte && (byte_count_ff < sfr_pkg::FRAME_LEN)) begin
         frame_ff[byte_count_ff] <= item.rx_byte;
      end
   end

   // Closed frame record.
   assign rec_push         = close_frame;
   assign rec.short_frame  = (byte_count_ff < sfr_pkg::FRAME_LEN);
   assign rec.header       = frame_ff[0];
   assign rec.error_code   = {frame_ff[2], frame_ff[1]};
   assign rec.rpm          = {frame_ff[4], frame_ff[3]};
   assign rec.check        = {frame_ff[8], frame_ff[7]};
   assign rec.sum          = sum_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/sfr_queue.sv
// Short queue of closed frames between the front and the back.
`timescale 1ns / 1ps
`default_nettype none
module sfr_queue #(
   parameter int DEPTH = 2
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire sfr_pkg::frame_rec_type push_rec,
   input  wire logic                   pop,
   output logic                        not_empty,
   output logic                        full,
   output sfr_pkg::frame_rec_type      head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   sfr_pkg::frame_rec_type store_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;
   logic          do_push, do_pop;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == FULL_COUNT);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head      = store_ff[rd_ptr_ff];

   // Pointers and fill count.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule
`default_nettype wire

FILE: hw/rtl/sfr_back.sv
// Back end: judges a closed frame and holds the result word.
`timescale 1ns / 1ps
`default_nettype none
module sfr_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   rec_valid,
   input  wire sfr_pkg::frame_rec_type rec,
   output logic                        rec_pop,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output sfr_pkg::rsp_type            rsp_data
);

   logic             rsp_valid_ff;
   sfr_pkg::rsp_type rsp_ff, rsp_in;

   // Errors in priority order: short frame, header, checksum.
   always_comb begin
      rsp_in.status     = sfr_pkg::STATUS_OK;
      rsp_in.error_code = 16'h0000;
      rsp_in.rpm        = 16'h0000;
      if (rec.short_frame) begin
         rsp_in.status = sfr_pkg::STATUS_SHORT;
      end else if (rec.header != sfr_pkg::HEADER_BYTE) begin
         rsp_in.status = sfr_pkg::STATUS_BAD_HEADER;
      end else if (rec.check != rec.sum) begin
         rsp_in.status = sfr_pkg::STATUS_BAD_CHECKSUM;
      end else begin
         rsp_in.error_code = rec.error_code;
         rsp_in.rpm        = rec.rpm;
      end
   end

   // Load the output register when it is empty or being taken.
   assign rec_pop = rec_valid && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rec_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

FILE: hw/rtl/serial_frame_receiver_checksum_top.sv
// Top level of the serial frame receiver with checksum check.
// One request word is taken per cycle; bytes and ticks never wait on each other.
// A tick that closes a frame gives its result word through the frame queue
// and then the output register of the judging stage.
// Requests stall only while the frame queue is full.
// Synchronous reset clears counts, queue and output valid; idle timeout returns to 20.
`timescale 1ns / 1ps
`default_nettype none
module serial_frame_receiver_checksum_top #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire sfr_pkg::req_type                    req_data,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output sfr_pkg::rsp_type                         rsp_data,
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [sfr_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [31:0]                         csr_pwdata,
   output logic [31:0]                              csr_prdata,
   output logic                                     csr_pready
);

   logic                   timeout_sel;
   logic [7:0]             timeout_ff;
   logic                   req_accept, rec_push, rec_pop, q_not_empty, q_full;
   sfr_pkg::frame_rec_type push_rec, head_rec;

   // Register file: one word, index taken from the word address.
   assign csr_pready = 1'b1;
   assign timeout_sel = (csr_paddr[2] == sfr_pkg::REG_IDLE_TIMEOUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= sfr_pkg::TIMEOUT_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && timeout_sel) begin
         timeout_ff <= csr_pwdata[7:0];
      end
   end

   assign csr_prdata = timeout_sel ? {24'h000000, timeout_ff} : 32'h00000000;

   // Request handshake.
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   sfr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .item_accept  (req_accept),
      .item         (req_data),
      .idle_timeout (timeout_ff),
      .rec_push     (rec_push),
      .rec          (push_rec)
   );

   sfr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_rec  (push_rec),
      .pop       (rec_pop),
      .not_empty (q_not_empty),
      .full      (q_full),
      .head      (head_rec)
   );

   sfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .rec_valid (q_not_empty),
      .rec       (head_rec),
      .rec_pop   (rec_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
